[hdl/midi_note_on_off_pairing_top_assert.svh]
// Assertion macros shared by the pairing block.
`ifndef MIDI_NOTE_ON_OFF_PAIRING_TOP_ASSERT_SVH
`define MIDI_NOTE_ON_OFF_PAIRING_TOP_ASSERT_SVH

// Checked outside reset only.
`define MNOP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define MNOP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/mnop_pkg.sv]
package mnop_pkg;

  localparam int CHANNEL_COUNT = 16;
  localparam int KEY_COUNT     = 128;
  localparam int STACK_DEPTH   = 4;
  localparam int INDEX_BITS    = 16;

  localparam int SLOT_COUNT  = CHANNEL_COUNT * KEY_COUNT;
  localparam int SLOT_W      = $clog2(SLOT_COUNT);
  localparam int STORE_COUNT = SLOT_COUNT * STACK_DEPTH;
  localparam int STORE_AW    = $clog2(STORE_COUNT);
  localparam int STORE_W     = 32 + INDEX_BITS;
  localparam int LVL_W       = $clog2(STACK_DEPTH + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  // classified event kind carried through the queue
  typedef enum logic [1:0] {
    EV_ON    = 2'd0,
    EV_OFF   = 2'd1,
    EV_OTHER = 2'd2
  } ev_t;

  // result kind codes on the output
  typedef enum logic [1:0] {
    RK_START = 2'd0,
    RK_CLOSE = 2'd1,
    RK_OTHER = 2'd2
  } res_kind_t;

  typedef struct packed {
    logic                  cmd;
    ev_t                   ev;
    logic [31:0]           tick;
    logic [INDEX_BITS-1:0] idx;
    logic                  chan_ok;
    logic [SLOT_W-1:0]     slot;
    logic [3:0]            chan;
    logic [6:0]            key;
    logic [6:0]            d2;
    logic [7:0]            type_cd;
  } q_entry_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  typedef struct packed {
    res_kind_t   kind;
    logic [15:0] event_index;
    logic [31:0] abs_tick;
    logic [3:0]  channel_out;
    logic [6:0]  key_out;
    logic [6:0]  data2_out;
    logic [31:0] note_length;
    logic [6:0]  release_velocity;
    logic [7:0]  type_out;
    logic        stack_overflow;
  } result_t;

endpackage

[hdl/mnop_ram.sv]
module mnop_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/mnop_front.sv]
module mnop_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  cmd,
  input  logic [27:0]           delta_ticks,
  input  logic [1:0]            event_kind,
  input  logic [7:0]            type_code,
  input  logic [3:0]            channel,
  input  logic [6:0]            key_or_data1,
  input  logic [6:0]            data2,
  input  logic                  q_full,
  input  mnop_pkg::back_status_t bstat,
  output logic                  push,
  output mnop_pkg::q_entry_t    push_data
);

  logic [31:0]                     running_tick;
  logic [mnop_pkg::INDEX_BITS-1:0] emit_counter;
  logic [31:0]                     tick_sum;
  logic                            takes_index;
  mnop_pkg::ev_t                   ev;

  assign in_ready = !q_full && !bstat.clearing;
  assign push     = in_valid && in_ready;
  assign tick_sum = running_tick + 32'(delta_ticks);

  always_comb begin
    case (event_kind)
      mnop_pkg::EV_ON:  ev = mnop_pkg::EV_ON;
      mnop_pkg::EV_OFF: ev = mnop_pkg::EV_OFF;
      default:          ev = mnop_pkg::EV_OTHER;
    endcase
  end

  assign takes_index = (ev != mnop_pkg::EV_OFF);

  always_comb begin
    push_data.cmd     = cmd;
    push_data.ev      = ev;
    push_data.tick    = tick_sum;
    push_data.idx     = emit_counter;
    push_data.chan_ok = (5'(channel) < 5'(mnop_pkg::CHANNEL_COUNT));
    push_data.slot    = push_data.chan_ok ?
                        mnop_pkg::SLOT_W'(int'(channel) * mnop_pkg::KEY_COUNT
                                          + int'(key_or_data1)) : '0;
    push_data.chan    = channel;
    push_data.key     = key_or_data1;
    push_data.d2      = data2;
    push_data.type_cd = type_code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_tick <= '0;
      emit_counter <= '0;
    end else if (push) begin
      if (cmd) begin
        running_tick <= '0;
        emit_counter <= '0;
      end else begin
        running_tick <= tick_sum;
        if (takes_index) begin
          emit_counter <= emit_counter + 1'b1;
        end
      end
    end
  end

endmodule

[hdl/mnop_queue.sv]
module mnop_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mnop_pkg::q_entry_t push_data,
  output logic               full,
  input  logic               pop,
  output mnop_pkg::q_entry_t head,
  output logic               empty
);

  localparam logic [mnop_pkg::QA_W-1:0] LAST = mnop_pkg::QA_W'(mnop_pkg::QUEUE_DEPTH - 1);

  mnop_pkg::q_entry_t          mem [mnop_pkg::QUEUE_DEPTH];
  logic [mnop_pkg::QA_W-1:0]   wr_ptr;
  logic [mnop_pkg::QA_W-1:0]   rd_ptr;
  logic [mnop_pkg::QC_W-1:0]   count;
  logic                        do_push;
  logic                        do_pop;

  assign full    = (count == mnop_pkg::QC_W'(mnop_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign head    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/mnop_back.sv]
`include "midi_note_on_off_pairing_top_assert.svh"

module mnop_back (
  input  logic                   clk,
  input  logic                   rst,
  input  mnop_pkg::q_entry_t     head,
  input  logic                   q_empty,
  output logic                   pop,
  output mnop_pkg::back_status_t bstat,
  output logic                   out_valid,
  input  logic                   out_ready,
  output mnop_pkg::result_t      res
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ACT  = 4'b0010,
    S_RD   = 4'b0100,
    S_CLR  = 4'b1000
  } state_t;

  localparam logic [mnop_pkg::SLOT_W-1:0] CLR_LAST = mnop_pkg::SLOT_W'(mnop_pkg::SLOT_COUNT - 1);

  function automatic logic [mnop_pkg::STORE_AW-1:0] store_pos(
    input logic [mnop_pkg::SLOT_W-1:0] slot,
    input logic [mnop_pkg::LVL_W-1:0]  lvl
  );
    return mnop_pkg::STORE_AW'(int'(slot) * mnop_pkg::STACK_DEPTH + int'(lvl));
  endfunction

  state_t                          state, state_next;
  mnop_pkg::q_entry_t              cur;
  logic [mnop_pkg::SLOT_W-1:0]     clr_cnt;
  logic                            out_free;
  logic                            load;
  mnop_pkg::result_t               res_next;

  logic                            lvl_we, lvl_re;
  logic [mnop_pkg::SLOT_W-1:0]     lvl_waddr;
  logic [mnop_pkg::LVL_W-1:0]      lvl_wdata, lvl_rd, lvl_dec;
  logic                            st_we, st_re;
  logic [mnop_pkg::STORE_W-1:0]    st_rd;
  logic [31:0]                     st_tick;
  logic                            can_push;

  assign out_free = !out_valid || out_ready;
  assign lvl_dec  = lvl_rd - mnop_pkg::LVL_W'(1);
  assign st_tick  = st_rd[mnop_pkg::STORE_W-1 -: 32];
  assign can_push = cur.chan_ok && (lvl_rd < mnop_pkg::LVL_W'(mnop_pkg::STACK_DEPTH));

  assign bstat.clearing = (state == S_CLR);

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load       = 1'b0;
    lvl_re     = 1'b0;
    lvl_we     = 1'b0;
    lvl_waddr  = cur.slot;
    lvl_wdata  = lvl_rd;
    st_we      = 1'b0;
    st_re      = 1'b0;
    res_next   = '0;
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          if (head.cmd) begin
            pop        = 1'b1;
            state_next = S_CLR;
          end else if (head.ev == mnop_pkg::EV_OTHER) begin
            if (out_free) begin
              pop                  = 1'b1;
              load                 = 1'b1;
              res_next.kind        = mnop_pkg::RK_OTHER;
              res_next.event_index = 16'(head.idx);
              res_next.abs_tick    = head.tick;
              res_next.channel_out = head.chan;
              res_next.key_out     = head.key;
              res_next.data2_out   = head.d2;
              res_next.type_out    = head.type_cd;
            end
          end else begin
            pop        = 1'b1;
            lvl_re     = 1'b1;
            state_next = S_ACT;
          end
        end
      end
      S_ACT: begin
        if (cur.ev == mnop_pkg::EV_ON) begin
          if (out_free) begin
            load                    = 1'b1;
            res_next.kind           = mnop_pkg::RK_START;
            res_next.event_index    = 16'(cur.idx);
            res_next.abs_tick       = cur.tick;
            res_next.channel_out    = cur.chan;
            res_next.key_out        = cur.key;
            res_next.data2_out      = cur.d2;
            res_next.stack_overflow = !can_push;
            if (can_push) begin
              st_we     = 1'b1;
              lvl_we    = 1'b1;
              lvl_wdata = lvl_rd + mnop_pkg::LVL_W'(1);
            end
            state_next = S_IDLE;
          end
        end else if (!cur.chan_ok || lvl_rd == '0) begin
          // unmatched note-off: nothing to emit
          state_next = S_IDLE;
        end else begin
          lvl_we     = 1'b1;
          lvl_wdata  = lvl_dec;
          st_re      = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        if (out_free) begin
          load                      = 1'b1;
          res_next.kind             = mnop_pkg::RK_CLOSE;
          res_next.event_index      = 16'(st_rd[mnop_pkg::INDEX_BITS-1:0]);
          res_next.abs_tick         = cur.tick;
          res_next.channel_out      = cur.chan;
          res_next.key_out          = cur.key;
          res_next.note_length      = cur.tick - st_tick;
          res_next.release_velocity = cur.d2;
          state_next                = S_IDLE;
        end
      end
      S_CLR: begin
        lvl_we    = 1'b1;
        lvl_waddr = clr_cnt;
        lvl_wdata = '0;
        if (clr_cnt == CLR_LAST) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLR;
      end
    endcase
  end

  mnop_ram #(
    .WIDTH (mnop_pkg::LVL_W),
    .DEPTH (mnop_pkg::SLOT_COUNT)
  ) u_level (
    .clk   (clk),
    .we    (lvl_we),
    .waddr (lvl_waddr),
    .wdata (lvl_wdata),
    .re    (lvl_re),
    .raddr (head.slot),
    .rdata (lvl_rd)
  );

  mnop_ram #(
    .WIDTH (mnop_pkg::STORE_W),
    .DEPTH (mnop_pkg::STORE_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (store_pos(cur.slot, lvl_rd)),
    .wdata ({cur.tick, cur.idx}),
    .re    (st_re),
    .raddr (store_pos(cur.slot, lvl_dec)),
    .rdata (st_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLR) begin
        clr_cnt <= (clr_cnt == CLR_LAST) ? '0 : clr_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && lvl_re) begin
      cur <= head;
    end
    if (load) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `MNOP_ASSERT(a_no_pop_clearing, (state == S_CLR) |-> !pop, "pop during clearing pass")
  `MNOP_ASSERT(a_load_free, load |-> (!out_valid || out_ready), "result overwrites pending result")
  `MNOP_ASSERT(a_lvl_bound, lvl_we |-> (lvl_wdata <= mnop_pkg::LVL_W'(mnop_pkg::STACK_DEPTH)),
    "stack level above depth")
  `MNOP_ASSERT(a_cmd_clears, (pop && head.cmd) |=> (state == S_CLR), "new track did not clear")
  `MNOP_ASSERT_ALWAYS(a_rst_clear, rst |=> (state == S_CLR && !out_valid),
    "reset did not start clearing pass")

endmodule

[hdl/midi_note_on_off_pairing_top.sv]
// channel  handshake              payload
// in       in_valid / in_ready    cmd delta_ticks event_kind type_code channel key_or_data1 data2
// out      out_valid / out_ready  kind event_index abs_tick channel_out key_out data2_out
//                                 note_length release_velocity type_out stack_overflow
//
// Front takes one transaction per cycle into a 4-entry queue while it has room.
// Back: other events load from idle; note-on passes the act state, note-off the act and read
// states (act only with nothing open), set by the level read and the tick/serial store read.
// Reset and every new-track command run a clearing pass over the 2048 stack
// levels, one per cycle; in_ready stays low while it runs.
// A stalled output holds in its register; the queue keeps taking input while it has room.
module midi_note_on_off_pairing_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [27:0] delta_ticks,
  input  logic [1:0]  event_kind,
  input  logic [7:0]  type_code,
  input  logic [3:0]  channel,
  input  logic [6:0]  key_or_data1,
  input  logic [6:0]  data2,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [15:0] event_index,
  output logic [31:0] abs_tick,
  output logic [3:0]  channel_out,
  output logic [6:0]  key_out,
  output logic [6:0]  data2_out,
  output logic [31:0] note_length,
  output logic [6:0]  release_velocity,
  output logic [7:0]  type_out,
  output logic        stack_overflow
);

  mnop_pkg::q_entry_t     push_data;
  mnop_pkg::q_entry_t     head;
  mnop_pkg::back_status_t bstat;
  mnop_pkg::result_t      res;
  logic                   push, pop, q_full, q_empty;

  mnop_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .delta_ticks  (delta_ticks),
    .event_kind   (event_kind),
    .type_code    (type_code),
    .channel      (channel),
    .key_or_data1 (key_or_data1),
    .data2        (data2),
    .q_full       (q_full),
    .bstat        (bstat),
    .push         (push),
    .push_data    (push_data)
  );

  mnop_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  mnop_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .bstat     (bstat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign kind             = res.kind;
  assign event_index      = res.event_index;
  assign abs_tick         = res.abs_tick;
  assign channel_out      = res.channel_out;
  assign key_out          = res.key_out;
  assign data2_out        = res.data2_out;
  assign note_length      = res.note_length;
  assign release_velocity = res.release_velocity;
  assign type_out         = res.type_out;
  assign stack_overflow   = res.stack_overflow;

endmodule

[bench/midi_note_on_off_pairing_top_tb.sv]
`timescale 1ns / 100ps

module midi_note_on_off_pairing_top_tb;

  localparam bit         CMD_EVENT     = 1'b0;
  localparam bit         CMD_NEW_TRACK = 1'b1;
  localparam logic [1:0] EV_UNUSED     = 2'd3;  // decoded as an other event
  localparam bit [27:0]  DELTA_MAX     = '1;
  localparam int         RANDOM_EVENTS = 1027;
  localparam int         NEW_TRACK_CAP = 20;

  typedef struct packed {
    bit         cmd;
    bit [27:0]  delta;
    logic [1:0] kind;
    bit [7:0]   code;
    bit [3:0]   channel;
    bit [6:0]   key;
    bit [6:0]   data2;
  } track_event_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        cmd;
  logic [27:0] delta_ticks;
  logic [1:0]  event_kind;
  logic [7:0]  type_code;
  logic [3:0]  channel;
  logic [6:0]  key_or_data1;
  logic [6:0]  data2;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  kind;
  logic [15:0] event_index;
  logic [31:0] abs_tick;
  logic [3:0]  channel_out;
  logic [6:0]  key_out;
  logic [6:0]  data2_out;
  logic [31:0] note_length;
  logic [6:0]  release_velocity;
  logic [7:0]  type_out;
  logic        stack_overflow;

  midi_note_on_off_pairing_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .delta_ticks(delta_ticks), .event_kind(event_kind),
    .type_code(type_code), .channel(channel), .key_or_data1(key_or_data1),
    .data2(data2),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .event_index(event_index), .abs_tick(abs_tick),
    .channel_out(channel_out), .key_out(key_out), .data2_out(data2_out),
    .note_length(note_length), .release_velocity(release_velocity),
    .type_out(type_out), .stack_overflow(stack_overflow)
  );

  // pairing state mirrored by the predictor
  bit [31:0]                     track_tick;
  bit [mnop_pkg::INDEX_BITS-1:0] serial_count;
  bit [31:0]                     open_tick [mnop_pkg::STORE_COUNT];
  bit [mnop_pkg::INDEX_BITS-1:0] open_serial [mnop_pkg::STORE_COUNT];
  int                            stack_fill [mnop_pkg::SLOT_COUNT];

  track_event_t      pending_events[$];
  mnop_pkg::result_t expected_results[$];
  int                total_events;
  int                accepted_events;
  int                error_count;
  int                new_tracks;

  bit in_taken;
  bit out_taken;
  bit in_calm;
  bit out_calm;
  int in_hold;
  int out_hold;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic queue_event(input track_event_t e);
    pending_events.insert(pending_events.size(), e);
  endtask

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic track_event_t make_event(input bit c, input bit [27:0] d,
                                              input logic [1:0] k, input bit [7:0] t,
                                              input bit [3:0] ch, input bit [6:0] ky,
                                              input bit [6:0] d2);
    track_event_t e;
    e.cmd = c;
    e.delta = d;
    e.kind = k;
    e.code = t;
    e.channel = ch;
    e.key = ky;
    e.data2 = d2;
    return e;
  endfunction

  // Returns 1 when the event produces a result; updates the mirrored state.
  function automatic bit pair_note_event(input track_event_t e, output mnop_pkg::result_t res);
    bit chan_ok;
    int slot;
    int pos;
    res = '0;
    if (e.cmd == CMD_NEW_TRACK) begin
      track_tick = '0;
      serial_count = '0;
      foreach (stack_fill[i]) stack_fill[i] = 0;
      return 1'b0;
    end
    track_tick = track_tick + 32'(e.delta);
    chan_ok = int'(e.channel) < mnop_pkg::CHANNEL_COUNT;
    slot = chan_ok ? int'(e.channel) * mnop_pkg::KEY_COUNT + int'(e.key) : 0;
    res.abs_tick = track_tick;
    res.channel_out = e.channel;
    res.key_out = e.key;
    if (e.kind == mnop_pkg::EV_ON) begin
      res.kind = mnop_pkg::RK_START;
      res.event_index = 16'(serial_count);
      res.data2_out = e.data2;
      res.stack_overflow = 1'b1;
      if (chan_ok && stack_fill[slot] < mnop_pkg::STACK_DEPTH) begin
        pos = slot * mnop_pkg::STACK_DEPTH + stack_fill[slot];
        open_tick[pos] = track_tick;
        open_serial[pos] = serial_count;
        stack_fill[slot]++;
        res.stack_overflow = 1'b0;
      end
      serial_count++;
      return 1'b1;
    end
    if (e.kind == mnop_pkg::EV_OFF) begin
      if (!chan_ok || stack_fill[slot] == 0) return 1'b0;
      stack_fill[slot]--;
      pos = slot * mnop_pkg::STACK_DEPTH + stack_fill[slot];
      res.kind = mnop_pkg::RK_CLOSE;
      res.event_index = 16'(open_serial[pos]);
      res.note_length = track_tick - open_tick[pos];
      res.release_velocity = e.data2;
      return 1'b1;
    end
    res.kind = mnop_pkg::RK_OTHER;
    res.event_index = 16'(serial_count);
    res.data2_out = e.data2;
    res.type_out = e.code;
    serial_count++;
    return 1'b1;
  endfunction

  function automatic track_event_t random_event();
    track_event_t e;
    int pick;
    e.cmd = CMD_EVENT;
    e.code = 8'($urandom);
    e.data2 = 7'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 60) e.delta = 28'($urandom_range(0, 255));
    else if (pick < 85) e.delta = 28'($urandom);
    else if (pick < 95) e.delta = '0;
    else e.delta = DELTA_MAX;
    // most events hit a few keys so stacks fill, pop and overflow
    if ($urandom_range(0, 3) != 0) begin
      e.channel = ($urandom_range(0, 2) == 0) ? 4'd15 : 4'($urandom_range(0, 1));
      e.key = 7'(60 + $urandom_range(0, 3));
    end else begin
      e.channel = 4'($urandom);
      e.key = 7'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 40) e.kind = mnop_pkg::EV_ON;
    else if (pick < 78) e.kind = mnop_pkg::EV_OFF;
    else if (pick < 96) e.kind = mnop_pkg::EV_OTHER;
    else e.kind = EV_UNUSED;
    return e;
  endfunction

  task automatic compare_result(input mnop_pkg::result_t want);
    if (kind != want.kind) report_mismatch("kind", kind, want.kind);
    if (event_index != want.event_index)
      report_mismatch("event_index", event_index, want.event_index);
    if (abs_tick != want.abs_tick) report_mismatch("abs_tick", abs_tick, want.abs_tick);
    if (channel_out != want.channel_out)
      report_mismatch("channel_out", channel_out, want.channel_out);
    if (key_out != want.key_out) report_mismatch("key_out", key_out, want.key_out);
    if (data2_out != want.data2_out)
      report_mismatch("data2_out", data2_out, want.data2_out);
    if (note_length != want.note_length)
      report_mismatch("note_length", note_length, want.note_length);
    if (release_velocity != want.release_velocity)
      report_mismatch("release_velocity", release_velocity, want.release_velocity);
    if (type_out != want.type_out) report_mismatch("type_out", type_out, want.type_out);
    if (stack_overflow != want.stack_overflow)
      report_mismatch("stack_overflow", stack_overflow, want.stack_overflow);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // input side: accept at the rising edge, predict right away
  always @(posedge clk) begin : in_accept
    track_event_t e;
    mnop_pkg::result_t res;
    in_taken <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      e = make_event(cmd, delta_ticks, event_kind, type_code, channel, key_or_data1, data2);
      if (pair_note_event(e, res)) expected_results.insert(expected_results.size(), res);
      accepted_events++;
    end
  end

  always @(negedge clk) begin : in_drive
    track_event_t e;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_hold > 0) begin
        in_valid <= 1'b0;
        in_hold--;
      end else if (pending_events.size() != 0) begin
        e = pending_events.pop_front();
        cmd <= e.cmd;
        delta_ticks <= e.delta;
        event_kind <= e.kind;
        type_code <= e.code;
        channel <= e.channel;
        key_or_data1 <= e.key;
        data2 <= e.data2;
        in_valid <= 1'b1;
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        in_hold = draw_wait(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side
  always @(posedge clk) begin : out_check
    out_taken <= !rst && out_valid && out_ready;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) report_mismatch("result with none pending", kind, 0);
      else compare_result(expected_results.pop_front());
    end
  end

  always @(negedge clk) begin
    if (out_taken) begin
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      out_hold = draw_wait(out_calm);
    end
    if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    track_event_t e;
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    cmd = CMD_EVENT;
    delta_ticks = '0;
    event_kind = mnop_pkg::EV_ON;
    type_code = '0;
    channel = '0;
    key_or_data1 = '0;
    data2 = '0;

    // new track with all other fields at their top values: ignored
    queue_event(make_event(CMD_NEW_TRACK, DELTA_MAX, EV_UNUSED, 8'hff, 4'd15, 7'd127, 7'd127));
    queue_event(make_event(CMD_EVENT, 28'd0, mnop_pkg::EV_ON, 8'h00, 4'd0, 7'd0, 7'd0));
    queue_event(make_event(CMD_EVENT, DELTA_MAX, mnop_pkg::EV_ON, 8'hff, 4'd15, 7'd127,
                           7'd127));
    queue_event(make_event(CMD_EVENT, 28'd5, mnop_pkg::EV_OFF, 8'h5a, 4'd15, 7'd127, 7'd127));
    // nothing left open on this key
    queue_event(make_event(CMD_EVENT, 28'd1, mnop_pkg::EV_OFF, 8'h00, 4'd15, 7'd127, 7'd64));
    queue_event(make_event(CMD_EVENT, DELTA_MAX, mnop_pkg::EV_OTHER, 8'hff, 4'd9, 7'd127,
                           7'd127));
    queue_event(make_event(CMD_EVENT, 28'd3, EV_UNUSED, 8'h00, 4'd6, 7'd1, 7'd2));
    // five starts on one key: the last one does not fit
    for (int i = 0; i < 5; i++)
      queue_event(make_event(CMD_EVENT, DELTA_MAX, mnop_pkg::EV_ON, 8'h00, 4'd3, 7'd64,
                             7'(10 + i)));
    // pops come back newest first, then one finds the stack empty
    for (int i = 0; i < 5; i++)
      queue_event(make_event(CMD_EVENT, DELTA_MAX, mnop_pkg::EV_OFF, 8'h00, 4'd3, 7'd64,
                             7'(100 + i)));
    queue_event(make_event(CMD_EVENT, DELTA_MAX, mnop_pkg::EV_OFF, 8'hff, 4'd0, 7'd0, 7'd127));
    queue_event(make_event(CMD_EVENT, 28'd0, mnop_pkg::EV_OTHER, 8'h00, 4'd0, 7'd0, 7'd0));
    // a note left open across a new track is forgotten
    queue_event(make_event(CMD_EVENT, 28'd7, mnop_pkg::EV_ON, 8'h00, 4'd5, 7'd10, 7'd33));
    queue_event(make_event(CMD_NEW_TRACK, 28'd0, mnop_pkg::EV_ON, 8'h00, 4'd0, 7'd0, 7'd0));
    queue_event(make_event(CMD_EVENT, 28'd2, mnop_pkg::EV_OFF, 8'h00, 4'd5, 7'd10, 7'd44));

    for (int i = 0; i < RANDOM_EVENTS; i++) begin
      e = random_event();
      if ($urandom_range(0, 99) < 2 && new_tracks < NEW_TRACK_CAP) begin
        e.cmd = CMD_NEW_TRACK;
        new_tracks++;
      end
      queue_event(e);
    end
    total_events = pending_events.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (accepted_events != total_events) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("midi_note_on_off_pairing_top: match");
    end else begin
      $display("midi_note_on_off_pairing_top: mismatch");
    end
    $finish;
  end

  // reset and each new track run a clearing pass over all 2048 stack levels; this lies far beyond them
  initial begin
    #5000000;
    $display("midi_note_on_off_pairing_top: mismatch");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/mnop_pkg.sv
hdl/mnop_ram.sv
hdl/mnop_front.sv
hdl/mnop_queue.sv
hdl/mnop_back.sv
hdl/midi_note_on_off_pairing_top.sv
bench/midi_note_on_off_pairing_top_tb.sv
